>>> rtl/strongest_station_top_k_macros.svh
// assertion macros shared by the strongest station block
`ifndef STRONGEST_STATION_TOP_K_MACROS_SVH
`define STRONGEST_STATION_TOP_K_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssk assertion failed");

// next-cycle implication, disabled while reset is low
`define SSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssk assertion failed");

`endif

>>> rtl/ssk_pkg.sv
// shared types and constants of the strongest station block
`default_nettype none

package ssk_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int FREQ_W    = 17;
    localparam int STR_W     = 8;
    localparam int WV_W      = STR_W + 1;
    localparam int IDX_OUT_W = 4;

    localparam logic [WV_W-1:0] WEAK_INIT = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    // ring control handed from the sequencer to every cell
    typedef struct packed {
        logic rotate;
        logic write;
    } t_ring_ctl;

endpackage

`default_nettype wire

>>> rtl/ssk_if.sv
// request channels of the strongest station block
`default_nettype none

interface ssk_in_if;
    import ssk_pkg::*;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_khz;
    logic [STR_W-1:0]  strength;

    modport source (output valid, output freq_khz, output strength, input ready);
    modport sink   (input valid, input freq_khz, input strength, output ready);
endinterface

interface ssk_out_if;
    import ssk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [FREQ_W-1:0]    slot_freq_khz;
    logic [STR_W-1:0]     slot_strength;
    logic                 last_slot;

    modport source (output valid, output slot_index, output slot_freq_khz,
                    output slot_strength, output last_slot, input ready);
    modport sink   (input valid, input slot_index, input slot_freq_khz,
                    input slot_strength, input last_slot, output ready);
endinterface

`default_nettype wire

>>> rtl/ssk_cell.sv
// one storage cell of the station ring
`default_nettype none

module ssk_cell import ssk_pkg::*; #(
    parameter int SLOT_ID = 0,
    parameter int IDX_W   = 4
) (
    input  wire logic              i_clk,
    input  wire t_ring_ctl         i_ctl,
    input  wire logic [IDX_W-1:0]  i_write_slot,
    input  wire logic [FREQ_W-1:0] i_freq,
    input  wire logic [STR_W-1:0]  i_str,
    input  wire logic [FREQ_W-1:0] i_next_freq,
    input  wire logic [STR_W-1:0]  i_next_str,
    output logic      [FREQ_W-1:0] o_freq,
    output logic      [STR_W-1:0]  o_str
);

    logic [FREQ_W-1:0] r_freq;
    logic [STR_W-1:0]  r_str;
    logic              sel;

    assign sel = i_ctl.write && (i_write_slot == IDX_W'(SLOT_ID));

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_freq <= i_freq;
            r_str  <= i_str;
        end else if (i_ctl.rotate) begin
            // take the neighbor's content, the ring turns by one
            r_freq <= i_next_freq;
            r_str  <= i_next_str;
        end
    end

    assign o_freq = r_freq;
    assign o_str  = r_str;

endmodule

`default_nettype wire

>>> rtl/ssk_ctrl.sv
// sequencer: fill, replacement, weakest search and slot report
`default_nettype none
`include "strongest_station_top_k_macros.svh"

module ssk_ctrl import ssk_pkg::*; #(
    parameter  int SLOTS = SLOTS_DEF,
    localparam int IW    = $clog2(SLOTS),
    localparam int CW    = $clog2(SLOTS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [FREQ_W-1:0]    i_freq,
    input  wire logic [STR_W-1:0]     i_str,
    input  wire logic [FREQ_W-1:0]    i_head_freq,
    input  wire logic [STR_W-1:0]     i_head_str,
    output t_ring_ctl                 o_ring,
    output logic      [IW-1:0]        o_write_slot,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [IDX_OUT_W-1:0] o_slot_index,
    output logic      [FREQ_W-1:0]    o_slot_freq,
    output logic      [STR_W-1:0]     o_slot_str,
    output logic                      o_last
);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill;
    logic [WV_W-1:0]   r_wv;
    logic [IW-1:0]     r_ws;
    logic [FREQ_W-1:0] r_prev;
    logic [IW-1:0]     r_step;
    logic              r_ovalid;
    logic [IDX_OUT_W-1:0] r_oidx;
    logic [FREQ_W-1:0] r_ofreq;
    logic [STR_W-1:0]  r_ostr;
    logic              r_olast;

    logic              in_fire;
    logic              filling;
    logic              repl;
    logic              wrap;
    logic              emit_load;
    logic              step_last;
    logic [IW+IDX_OUT_W-1:0] step_wide;

    assign in_fire   = i_in_valid && o_in_ready;
    assign filling   = r_fill < CW'(SLOTS);
    assign repl      = {1'b0, i_str} > r_wv;
    assign wrap      = i_freq < r_prev;
    assign emit_load = (r_state == ST_EMIT) && (!r_ovalid || i_out_ready);
    assign step_last = r_step == IW'(SLOTS - 1);
    assign step_wide = {{IDX_OUT_W{1'b0}}, r_step};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && !filling) begin
                    if (wrap) begin
                        n_state = ST_EMIT;
                    end else if (repl) begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (step_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_load && step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE) && i_rst_n;
        o_ring.rotate = (r_state == ST_SEARCH) || emit_load;
        o_ring.write  = in_fire && (filling || repl);
        o_write_slot  = filling ? r_fill[IW-1:0] : r_ws;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_wv     <= WEAK_INIT;
            r_ws     <= '0;
            r_prev   <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_step <= '0;
                if (filling) begin
                    r_fill <= r_fill + CW'(1);
                    r_prev <= i_freq;
                    if ({1'b0, i_str} < r_wv) begin
                        r_wv <= {1'b0, i_str};
                        r_ws <= r_fill[IW-1:0];
                    end
                end else begin
                    if (repl) begin
                        r_wv <= {1'b0, i_str};
                    end
                    if (!wrap) begin
                        r_prev <= i_freq;
                    end
                end
            end else if (r_state == ST_SEARCH) begin
                // head holds the slot numbered by the step counter
                if ({1'b0, i_head_str} < r_wv) begin
                    r_wv <= {1'b0, i_head_str};
                    r_ws <= r_step;
                end
                r_step <= step_last ? '0 : r_step + IW'(1);
            end
            if (emit_load) begin
                r_ovalid <= 1'b1;
                r_step   <= step_last ? '0 : r_step + IW'(1);
                if (step_last) begin
                    r_fill <= '0;
                    r_wv   <= WEAK_INIT;
                    r_ws   <= '0;
                    r_prev <= '0;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_oidx  <= step_wide[IDX_OUT_W-1:0];
            r_ofreq <= i_head_freq;
            r_ostr  <= i_head_str;
            r_olast <= step_last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_slot_index = r_oidx;
    assign o_slot_freq  = r_ofreq;
    assign o_slot_str   = r_ostr;
    assign o_last       = r_olast;

    `SSK_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(SLOTS))
    `SSK_ASSERT_IMP(a_wv_after_fill, i_clk, i_rst_n, r_fill != '0, !r_wv[WV_W-1])
    `SSK_ASSERT_NXT(a_search_ends, i_clk, i_rst_n,
        (r_state == ST_SEARCH) && step_last, r_state == ST_IDLE)
    `SSK_ASSERT_NXT(a_emit_clears, i_clk, i_rst_n, emit_load && step_last,
        (r_fill == '0) && (r_wv == WEAK_INIT) && r_ovalid && r_olast)

endmodule

`default_nettype wire

>>> rtl/strongest_station_top_k.sv
// strongest station keeper: a fill/replace-minimum scan
// fill-phase request: to the next free slot; a replacing request: weakest search, ring turn
// scan-end request: one report per slot, slowed only by output backpressure
// ring turns one step per cycle, held by backpressure in report; comparator sits at ring head
// synchronous active-low reset clears the sequencer, weakest tracker and output valid;
// slot contents are not reset and are overwritten by the fill of each scan
`default_nettype none

module strongest_station_top_k import ssk_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssk_in_if.sink    i_in,
    ssk_out_if.source o_out
);

    localparam int IW = $clog2(SLOTS);

    // ring taps, cell 0 is the head seen by the sequencer
    logic [FREQ_W-1:0] cell_freq [SLOTS];
    logic [STR_W-1:0]  cell_str  [SLOTS];

    t_ring_ctl         ring_ctl;
    logic [IW-1:0]     write_slot;
    logic              in_ready;
    logic              out_valid;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [FREQ_W-1:0] slot_freq;
    logic [STR_W-1:0]  slot_str;
    logic              last_slot;

    // sequencer: fill, replace the weakest, serial search, report
    ssk_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (in_ready),
        .i_freq       (i_in.freq_khz),
        .i_str        (i_in.strength),
        .i_head_freq  (cell_freq[0]),
        .i_head_str   (cell_str[0]),
        .o_ring       (ring_ctl),
        .o_write_slot (write_slot),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .o_slot_index (slot_index),
        .o_slot_freq  (slot_freq),
        .o_slot_str   (slot_str),
        .o_last       (last_slot)
    );

    // ring of cells: on rotate each cell takes its upper neighbor, the head wraps to the top
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ssk_cell #(
            .SLOT_ID (g),
            .IDX_W   (IW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ring_ctl),
            .i_write_slot (write_slot),
            .i_freq       (i_in.freq_khz),
            .i_str        (i_in.strength),
            .i_next_freq  (cell_freq[(g + 1) % SLOTS]),
            .i_next_str   (cell_str[(g + 1) % SLOTS]),
            .o_freq       (cell_freq[g]),
            .o_str        (cell_str[g])
        );
    end

    // channel hookup
    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.slot_index    = slot_index;
    assign o_out.slot_freq_khz = slot_freq;
    assign o_out.slot_strength = slot_str;
    assign o_out.last_slot     = last_slot;

endmodule

`default_nettype wire
